@@ src/d2d_pkg.sv @@
// Shared types, widths and constants for the disparity-to-depth pixel block.
`default_nettype none

package d2d_pkg;

    // Field and register widths
    localparam int DEPTH_W  = 24;   // depth output and range limit width
    localparam int DISP_W   = 16;   // input disparity
    localparam int FOCAL_W  = 24;   // focal term, signed Q15.8
    localparam int QCOEF_W  = 32;   // inverse baseline and offset, signed Q7.24
    localparam int FS_W     = 4;    // fraction shift register
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Denominator arithmetic
    localparam int PROD_W   = QCOEF_W + DISP_W;     // coefficient times disparity, and W
    localparam int ABSW_W   = PROD_W - 1;           // |W| always fits one bit less
    localparam int NUM_SH   = 20;                   // focal scale-up to depth units

    // Restoring divider: quotient never reaches 2^QUO_W since |W| > NEAR_ZERO
    localparam int QUO_W    = 29;
    localparam int DIV_CELLS = QUO_W;
    localparam int REM_W    = ABSW_W;
    localparam int CMP_W    = (QUO_W > DEPTH_W) ? QUO_W : DEPTH_W;

    localparam logic [ABSW_W-1:0] NEAR_ZERO      = ABSW_W'(16777);  // 0.001 in Q.24
    localparam logic [FS_W-1:0]   MAX_FRAC_SHIFT = FS_W'(8);
    localparam logic [7:0]        MASK_VALID     = 8'd255;
    localparam logic [7:0]        MASK_CLAMPED   = 8'd128;
    localparam logic [7:0]        MASK_INVALID   = 8'd0;

    // Register reset values
    localparam logic [FS_W-1:0]    FS_RESET    = FS_W'(4);
    localparam logic [DEPTH_W-1:0] MAX_D_RESET = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FOCAL     = 3'd0,
        CFG_INV_BASE  = 3'd1,
        CFG_OFFSET    = 3'd2,
        CFG_FRAC      = 3'd3,
        CFG_MIN_DEPTH = 3'd4,
        CFG_MAX_DEPTH = 3'd5,
        CFG_CLAMP     = 3'd6,
        CFG_NAN       = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_BAD_DISP  = 3'd0,
        ST_NEAR_ZERO = 3'd1,
        ST_VALID     = 3'd2,
        ST_CLAMPED   = 3'd3,
        ST_RANGE     = 3'd4
    } t_status;

    // Per-pixel side flags carried alongside the divider
    typedef struct packed {
        logic bad;      // disparity <= 0
        logic nz;       // |W| too small
        logic neg;      // quotient sign negative
    } t_flags;

    // One beat moving from cell to cell
    typedef struct packed {
        logic             vld;
        t_flags           flags;
        logic [REM_W-1:0] rem;  // partial remainder
        logic [REM_W-1:0] dvs;  // |W|
        logic [QUO_W-1:0] nq;   // dividend bits still to enter, quotient bits shifted in
    } t_div_beat;

endpackage

`default_nettype wire

@@ src/d2d_front.sv @@
// Front stages: input register, coefficient multiply, shift and offset add, divider setup.
`default_nettype none

module d2d_front
    import d2d_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_adv,
    input  wire logic                      i_valid,
    input  wire logic signed [DISP_W-1:0]  i_disparity_raw,
    input  wire logic signed [FOCAL_W-1:0] i_focal,
    input  wire logic signed [QCOEF_W-1:0] i_inv_base,
    input  wire logic signed [QCOEF_W-1:0] i_offset,
    input  wire logic        [FS_W-1:0]    i_frac_shift,
    output t_div_beat                      o_beat
);

    // Stage 1: input register
    logic                     r1_vld;
    logic signed [DISP_W-1:0] r1_raw;

    // Stage 2: product register
    logic                     r2_vld;
    logic                     r2_bad;
    logic signed [PROD_W-1:0] r2_prod;

    // Stage 3: divider setup
    t_div_beat r3_beat;
    t_div_beat n3_beat;

    logic signed [PROD_W-1:0]  w_prod;
    logic        [FS_W-1:0]    w_fs;
    logic signed [PROD_W-1:0]  w_scaled;
    logic signed [PROD_W-1:0]  w_den;
    logic        [ABSW_W-1:0]  w_absw;
    logic        [FOCAL_W-1:0] w_focal_abs;

    // Signed coefficient times disparity
    assign w_prod = PROD_W'(i_inv_base) * PROD_W'(r1_raw);

    // Floor shift by the fraction bits, then offset
    assign w_fs        = (i_frac_shift > MAX_FRAC_SHIFT) ? MAX_FRAC_SHIFT : i_frac_shift;
    assign w_scaled    = r2_prod >>> w_fs;
    assign w_den       = w_scaled + PROD_W'(i_offset);
    assign w_absw      = w_den[PROD_W-1] ? ABSW_W'(-w_den) : ABSW_W'(w_den);
    assign w_focal_abs = i_focal[FOCAL_W-1] ? FOCAL_W'(-i_focal) : FOCAL_W'(i_focal);

    // Numerator is |focal| << 20; the top bits start as the remainder
    always_comb begin
        n3_beat           = '0;
        n3_beat.vld       = r2_vld;
        n3_beat.flags.bad = r2_bad;
        n3_beat.flags.nz  = (w_absw <= NEAR_ZERO);
        n3_beat.flags.neg = i_focal[FOCAL_W-1] ^ w_den[PROD_W-1];
        n3_beat.dvs       = w_absw;
        n3_beat.rem       = REM_W'(w_focal_abs[FOCAL_W-1:QUO_W-NUM_SH]);
        n3_beat.nq        = {w_focal_abs[QUO_W-NUM_SH-1:0], NUM_SH'(0)};
    end

    // Valid bits and payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld      <= 1'b0;
            r2_vld      <= 1'b0;
            r3_beat.vld <= 1'b0;
        end else if (i_adv) begin
            r1_vld      <= i_valid;
            r2_vld      <= r1_vld;
            r3_beat.vld <= n3_beat.vld;
        end
        if (i_adv) begin
            r1_raw        <= i_disparity_raw;
            r2_bad        <= (r1_raw <= 0);
            r2_prod       <= w_prod;
            r3_beat.flags <= n3_beat.flags;
            r3_beat.rem   <= n3_beat.rem;
            r3_beat.dvs   <= n3_beat.dvs;
            r3_beat.nq    <= n3_beat.nq;
        end
    end

    assign o_beat = r3_beat;

endmodule

`default_nettype wire

@@ src/d2d_div_cell.sv @@
// One restoring-division cell: produces one quotient bit and passes the beat on.
`default_nettype none

module d2d_div_cell
    import d2d_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_adv,
    input  wire t_div_beat i_beat,
    output t_div_beat      o_beat
);

    t_div_beat      r_beat;
    t_div_beat      n_beat;
    logic [REM_W:0] w_trial;
    logic           w_qbit;

    // Bring down the next dividend bit and try the subtract
    assign w_trial = {i_beat.rem, i_beat.nq[QUO_W-1]};
    assign w_qbit  = (w_trial >= {1'b0, i_beat.dvs});

    always_comb begin
        n_beat     = i_beat;
        n_beat.rem = w_qbit ? REM_W'(w_trial - {1'b0, i_beat.dvs}) : REM_W'(w_trial);
        n_beat.nq  = {i_beat.nq[QUO_W-2:0], w_qbit};
    end

    // Valid bit with reset, payload without
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat.vld <= 1'b0;
        end else if (i_adv) begin
            r_beat.vld <= n_beat.vld;
        end
        if (i_adv) begin
            r_beat.flags <= n_beat.flags;
            r_beat.rem   <= n_beat.rem;
            r_beat.dvs   <= n_beat.dvs;
            r_beat.nq    <= n_beat.nq;
        end
    end

    assign o_beat = r_beat;

endmodule

`default_nettype wire

@@ src/disparity_to_depth_pixel_top.sv @@
// Top level: config registers, front stages, division cell chain and output stage.
//
// Usage:
//   Input channel (i_disp_valid / o_disp_ready) carries one signed disparity per beat.
//   Output channel (o_depth_valid / i_depth_ready) carries depth, NaN flag, mask code
//   and status, one result beat per input beat, in order.
//   Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data); write only
//   while no pixel is in flight.
// Throughput: one pixel per clock when the receiver is ready.
// Stages, from input acceptance to the output beat: input register,
//   multiply register, denominator register, 29 divider cells (one quotient bit
//   each) and the output register.
// The depth rate is set by the divider chain, which is fully pipelined.
// Reset (synchronous, active low) empties the pipeline and loads the register
//   defaults: frac shift 4, max depth all ones, NaN flagging on, others zero.
// Stall: when the output beat is held and i_depth_ready is low, the whole pipeline
//   freezes and o_disp_ready drops in the same cycle; no beat is lost or repeated.
`default_nettype none

module disparity_to_depth_pixel_top
    import d2d_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // config write port
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]    i_cfg_data,
    // disparity input
    input  wire logic                     i_disp_valid,
    output logic                          o_disp_ready,
    input  wire logic signed [DISP_W-1:0] i_disparity_raw,
    // depth output
    output logic                          o_depth_valid,
    input  wire logic                     i_depth_ready,
    output logic [DEPTH_W-1:0]            o_depth_value,
    output logic                          o_depth_is_nan,
    output logic [7:0]                    o_mask_code,
    output logic [2:0]                    o_pixel_status
);

    // Config registers
    logic signed [FOCAL_W-1:0] r_focal;
    logic signed [QCOEF_W-1:0] r_inv_base;
    logic signed [QCOEF_W-1:0] r_offset;
    logic        [FS_W-1:0]    r_frac_shift;
    logic        [DEPTH_W-1:0] r_min_depth;
    logic        [DEPTH_W-1:0] r_max_depth;
    logic                      r_clamp;
    logic                      r_nan_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal      <= '0;
            r_inv_base   <= '0;
            r_offset     <= '0;
            r_frac_shift <= FS_RESET;
            r_min_depth  <= '0;
            r_max_depth  <= MAX_D_RESET;
            r_clamp      <= 1'b0;
            r_nan_mode   <= 1'b1;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_FOCAL:     r_focal      <= i_cfg_data[FOCAL_W-1:0];
                CFG_INV_BASE:  r_inv_base   <= i_cfg_data[QCOEF_W-1:0];
                CFG_OFFSET:    r_offset     <= i_cfg_data[QCOEF_W-1:0];
                CFG_FRAC:      r_frac_shift <= i_cfg_data[FS_W-1:0];
                CFG_MIN_DEPTH: r_min_depth  <= i_cfg_data[DEPTH_W-1:0];
                CFG_MAX_DEPTH: r_max_depth  <= i_cfg_data[DEPTH_W-1:0];
                CFG_CLAMP:     r_clamp      <= i_cfg_data[0];
                CFG_NAN:       r_nan_mode   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Pipeline advance: whole chain moves unless the output beat is stuck
    logic r_out_valid;
    logic w_adv;

    assign w_adv        = !r_out_valid || i_depth_ready;
    assign o_disp_ready = w_adv;

    // Front stages
    t_div_beat w_chain [DIV_CELLS+1];

    d2d_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_adv           (w_adv),
        .i_valid         (i_disp_valid),
        .i_disparity_raw (i_disparity_raw),
        .i_focal         (r_focal),
        .i_inv_base      (r_inv_base),
        .i_offset        (r_offset),
        .i_frac_shift    (r_frac_shift),
        .o_beat          (w_chain[0])
    );

    // Divider cell chain, one quotient bit per cell
    for (genvar g = 0; g < DIV_CELLS; g++) begin : g_cell
        d2d_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_beat  (w_chain[g]),
            .o_beat  (w_chain[g+1])
        );
    end

    // Classification and range handling
    t_div_beat          w_last;
    logic [CMP_W-1:0]   w_depth;
    logic [CMP_W-1:0]   w_min;
    logic [CMP_W-1:0]   w_max;
    logic [CMP_W-1:0]   w_clip;
    logic [DEPTH_W-1:0] n_depth;
    logic               n_nan;
    logic [7:0]         n_mask;
    t_status            n_status;

    assign w_last  = w_chain[DIV_CELLS];
    assign w_depth = CMP_W'(w_last.nq);
    assign w_min   = CMP_W'(r_min_depth);
    assign w_max   = CMP_W'(r_max_depth);

    always_comb begin
        w_clip = (w_depth < w_max) ? w_depth : w_max;
        if (w_clip < w_min) begin
            w_clip = w_min;
        end
        n_depth  = '0;
        n_nan    = 1'b1;
        n_mask   = MASK_INVALID;
        n_status = ST_RANGE;
        if (w_last.flags.bad) begin
            n_nan    = r_nan_mode;
            n_status = ST_BAD_DISP;
        end else if (w_last.flags.nz) begin
            n_status = ST_NEAR_ZERO;
        end else if (w_depth == '0 || w_last.flags.neg) begin
            n_status = ST_RANGE;
        end else if (w_depth >= w_min && w_depth <= w_max) begin
            n_depth  = w_depth[DEPTH_W-1:0];
            n_nan    = 1'b0;
            n_mask   = MASK_VALID;
            n_status = ST_VALID;
        end else if (r_clamp) begin
            n_depth  = w_clip[DEPTH_W-1:0];
            n_nan    = 1'b0;
            n_mask   = MASK_CLAMPED;
            n_status = ST_CLAMPED;
        end
    end

    // Output register
    logic [DEPTH_W-1:0] r_depth;
    logic               r_nan;
    logic [7:0]         r_mask;
    t_status            r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_last.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_depth  <= n_depth;
            r_nan    <= n_nan;
            r_mask   <= n_mask;
            r_status <= n_status;
        end
    end

    assign o_depth_valid  = r_out_valid;
    assign o_depth_value  = r_depth;
    assign o_depth_is_nan = r_nan;
    assign o_mask_code    = r_mask;
    assign o_pixel_status = r_status;

`ifndef SYNTH
    // Input side must stall whenever a result is held back
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_depth_valid && !i_depth_ready) |-> !o_disp_ready)
        else $error("input accepted while output stalled");

    // Mask code agrees with status
    a_mask_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_depth_valid |-> ((o_mask_code == MASK_VALID) == (o_pixel_status == ST_VALID)) &&
                          ((o_mask_code == MASK_CLAMPED) == (o_pixel_status == ST_CLAMPED)))
        else $error("mask code and status disagree");

    // Rejected pixels carry zero depth
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_depth_valid && o_mask_code == MASK_INVALID) |-> (o_depth_value == '0))
        else $error("rejected pixel with nonzero depth");

    // A good depth never carries the NaN flag
    a_good_not_nan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_depth_valid && (o_pixel_status == ST_VALID || o_pixel_status == ST_CLAMPED))
        |-> !o_depth_is_nan)
        else $error("valid depth flagged NaN");
`endif

endmodule

`default_nettype wire
